// File: src/dpcr_pkg.sv
// ----------------------------------------------------------------------------
// dpcr_pkg
// Shared sizes and controller/datapath interface types for the demand
// paging translator with second-chance clock replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcr_pkg;

    // Address split and table sizes
    localparam int ADDR_W      = 16;
    localparam int PAGE_BITS   = 8;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 32;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int HAND_W      = $clog2(FRAME_COUNT + 1);

    // Result item packing
    localparam int PHYS_W      = 13;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_USED_W  = PHYS_W + FRAME_W + 1 + 1 + PAGE_W + 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch a new item, start the map read
        logic hit_commit;   // finish an item whose page is mapped
        logic free_commit;  // finish a fault that takes the next free frame
        logic sweep_step;   // examine one frame under the clock hand
        logic evict_commit; // finish a fault that replaces the victim
    } dpcr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic page_hit;     // page of the held item is mapped
        logic free_avail;   // a never-used frame is still available
        logic hand_ref;     // reference bit under the (wrapped) hand
        logic out_free;     // output register can take a result
    } dpcr_stat_t;

endpackage : dpcr_pkg

`default_nettype wire

// File: src/dpcr_ctrl.sv
// ----------------------------------------------------------------------------
// dpcr_ctrl
// Sequencer: lookup, free-frame allocation, clock sweep and eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dpcr_pkg::dpcr_stat_t stat,
    output dpcr_pkg::dpcr_cmd_t      cmd
);
    import dpcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_EVICT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.page_hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.hit_commit = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (stat.free_avail)
                begin
                    if (stat.out_free)
                    begin
                        cmd.free_commit = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (!stat.hand_ref)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (stat.out_free)
                begin
                    cmd.evict_commit = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule : dpcr_ctrl

`default_nettype wire

// File: src/dpcr_datapath.sv
// ----------------------------------------------------------------------------
// dpcr_datapath
// Page table, frame ownership, reference bits, clock hand and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [dpcr_pkg::ADDR_W-1:0]        in_addr,
    input  wire logic                               in_func,
    input  wire dpcr_pkg::dpcr_cmd_t                cmd,
    output dpcr_pkg::dpcr_stat_t                    stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dpcr_pkg::OUT_TDATA_W-1:0]        out_data
);
    import dpcr_pkg::*;

    // Held item
    logic                 func_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_BITS-1:0] offset_reg;

    // Page table and frame state; a mapped page owns exactly one frame,
    // so its dirty mark is kept with the frame
    logic [PAGE_COUNT-1:0]  valid_reg;
    logic [PAGE_COUNT-1:0]  valid_next;
    logic [FRAME_COUNT-1:0] frame_dirty_reg;
    logic [FRAME_COUNT-1:0] ref_reg;
    logic [HAND_W-1:0]      hand_reg;
    logic                   full_reg;
    logic [FRAME_W-1:0]     victim_frame_reg;

    // Memories: page to frame map, frame to owning page
    logic [FRAME_W-1:0] map_frame_mem [PAGE_COUNT];
    logic [FRAME_W-1:0] map_frame_rd_reg;
    logic [PAGE_W-1:0]  owner_mem [FRAME_COUNT];
    logic [PAGE_W-1:0]  owner_rd_reg;

    // Result register
    logic                 out_valid_reg;
    logic [PHYS_W-1:0]    out_phys_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic                 out_fault_reg;
    logic                 out_evicted_reg;
    logic [PAGE_W-1:0]    out_epage_reg;
    logic                 out_wb_reg;

    logic [PAGE_W-1:0]  in_page;
    logic [FRAME_W-1:0] hand_wrap;
    logic [FRAME_W-1:0] commit_frame;
    logic               commit_any;
    logic               commit_fault;
    logic [PAGE_W-1:0]  victim_page;

    assign in_page = PAGE_W'(in_addr >> PAGE_BITS);

    // Hand wraps to frame 0 before a look when it has run past the end
    assign hand_wrap = (hand_reg >= HAND_W'(FRAME_COUNT)) ? '0 : hand_reg[FRAME_W-1:0];

    assign commit_fault = cmd.free_commit | cmd.evict_commit;
    assign commit_any   = cmd.hit_commit | commit_fault;
    assign victim_page  = owner_rd_reg;

    // Frame the committed access ends up in
    always_comb
    begin
        if (cmd.hit_commit)
        begin
            commit_frame = map_frame_rd_reg;
        end
        else if (cmd.free_commit)
        begin
            commit_frame = hand_reg[FRAME_W-1:0];
        end
        else
        begin
            commit_frame = victim_frame_reg;
        end
    end

    // Valid marks: victim unmapped, new page mapped
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.evict_commit)
        begin
            valid_next[victim_page] = 1'b0;
        end
        if (commit_fault)
        begin
            valid_next[page_reg] = 1'b1;
        end
    end

    // Status to the controller
    assign stat.page_hit   = valid_reg[page_reg];
    assign stat.free_avail = !full_reg && (hand_reg < HAND_W'(FRAME_COUNT));
    assign stat.hand_ref   = ref_reg[hand_wrap];
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Held item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_func;
            page_reg   <= in_page;
            offset_reg <= in_addr[PAGE_BITS-1:0];
        end
    end

    // Map memory: read on capture, write on a fault commit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            map_frame_rd_reg <= map_frame_mem[in_page];
        end
        if (commit_fault)
        begin
            map_frame_mem[page_reg] <= commit_frame;
        end
    end

    // Owner memory: read the frame under the hand, write on a fault commit
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            owner_rd_reg <= owner_mem[hand_wrap];
        end
        if (commit_fault)
        begin
            owner_mem[commit_frame] <= page_reg;
        end
    end

    // Valid, dirty and reference bits, clock hand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            frame_dirty_reg <= '0;
            ref_reg         <= '0;
            hand_reg        <= '0;
            full_reg        <= 1'b0;
        end
        else
        begin
            // one look of the sweep: clear a set bit, or stop at a clear one; the hand moves on either way
            if (cmd.sweep_step)
            begin
                if (ref_reg[hand_wrap])
                begin
                    ref_reg[hand_wrap] <= 1'b0;
                end
                hand_reg <= HAND_W'(hand_wrap) + HAND_W'(1);
            end
            if (cmd.free_commit)
            begin
                hand_reg <= hand_reg + HAND_W'(1);
                if (hand_reg == HAND_W'(FRAME_COUNT - 1))
                begin
                    full_reg <= 1'b1;
                end
            end
            valid_reg <= valid_next;
            // new mapping starts clean unless written
            if (commit_fault)
            begin
                frame_dirty_reg[commit_frame] <= func_reg;
            end
            else if (cmd.hit_commit && func_reg)
            begin
                frame_dirty_reg[commit_frame] <= 1'b1;
            end
            if (commit_any)
            begin
                ref_reg[commit_frame] <= 1'b1;
            end
        end
    end

    // Remember the victim frame when the sweep stops
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step && !ref_reg[hand_wrap])
        begin
            victim_frame_reg <= hand_wrap;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (commit_any)
        begin
            out_phys_reg    <= PHYS_W'({commit_frame, offset_reg});
            out_frame_reg   <= commit_frame;
            out_fault_reg   <= commit_fault;
            out_evicted_reg <= cmd.evict_commit;
            out_epage_reg   <= cmd.evict_commit ? victim_page : '0;
            out_wb_reg      <= cmd.evict_commit && frame_dirty_reg[victim_frame_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_wb_reg, out_epage_reg,
                        out_evicted_reg, out_fault_reg, out_frame_reg, out_phys_reg};

endmodule : dpcr_datapath

`default_nettype wire

// File: src/demand_paging_clock_replacement_core.sv
// ----------------------------------------------------------------------------
// demand_paging_clock_replacement_core
// Logical to physical address translator with second-chance replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one access item, address on s_tdata, read/write on
//   s_tuser. Master channel m_*: one result item per access.
//   One access is handled at a time. A mapped page, or a fault served from
//   a never-used frame, is committed from the lookup state: its result is
//   registered as the block becomes ready again, in the same cycle.
//   A fault with all frames in use sweeps the clock hand, one frame a
//   cycle, 1 to FRAME_COUNT + 1 looks, then moves to the evict state,
//   which commits once the output register is free.
//   Reset clears all valid, dirty and reference bits and the hand at once;
//   no clearing pass is needed, the block is ready straight after reset.
//   A stalled master holds the result in the output register; the block
//   still accepts and looks up the next access and waits only at commit.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_paging_clock_replacement_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] virt_address
    input  wire logic [0:0]  s_tuser,   // [0] func (0 read, 1 write)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [12:0] phys_address, [17:13] frame_used,
                                        // [18] page_fault, [19] evicted,
                                        // [27:20] evicted_page, [28] needs_writeback
);
    import dpcr_pkg::*;

    dpcr_cmd_t  cmd;
    dpcr_stat_t stat;

    // Sequencer
    dpcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tables and result register
    dpcr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_addr   (s_tdata),
        .in_func   (s_tuser[0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One item in flight: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in progress");

    // A new result is only produced while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");

    // Without eviction the eviction fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[19] |-> m_tdata[28:20] == 9'd0)
        else $error("eviction details set without eviction");

    // An eviction is always a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> m_tdata[18])
        else $error("eviction reported without page fault");

endmodule : demand_paging_clock_replacement_core

`default_nettype wire
